// File: src/frbs_pkg.sv
// ----------------------------------------------------------------------------
// frbs_pkg
// Shared types, constants and fixed-point helpers for the fragment step core.
// ----------------------------------------------------------------------------
package frbs_pkg;

    // Signed Q16.16 value
    typedef logic signed [31:0] t_val;

    localparam t_val VMAX = {1'b0, {31{1'b1}}};
    localparam t_val VMIN = {1'b1, {31{1'b0}}};

    // Physics constants, Q16.16
    localparam t_val C_DRAG      = 32'sd18866;
    localparam t_val C_AREA      = 32'sd3277;
    localparam t_val C_AREA_MIN  = 32'sd66;
    localparam t_val C_SPEED_MIN = 32'sd655;
    localparam t_val C_FLOOR     = -32'sd32768;
    localparam t_val C_BOUNCE    = -32'sd22938;
    localparam t_val C_FRICTION  = 32'sd42598;
    localparam t_val C_HALF      = 32'sd32768;
    localparam t_val C_REST      = 32'sd6554;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Field select codes (0-12: vector components in store order)
    localparam logic [3:0] FS_MASS = 4'd13;
    localparam logic [3:0] FS_LIVE = 4'd14;
    localparam int         N_FIELDS = 14;

    // Configuration register indexes
    localparam logic [7:0] CFG_TIME_STEP = 8'd0;
    localparam logic [7:0] CFG_GRAVITY   = 8'd1;

    // Classified item kinds
    typedef enum logic [1:0] {
        OP_NOP,
        OP_WRITE,
        OP_STEP,
        OP_STEP_NULL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] idx;
        logic [3:0] sel;
        t_val       val;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic {
        IT_DIV,
        IT_SQRT
    } t_iter_mode;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_AREA, ST_VSQ, ST_VMAG, ST_VMAG_W,
        ST_DRAG0, ST_DRAG1, ST_DDIV, ST_DDIV_W, ST_DV0, ST_DV1, ST_GRAV,
        ST_POS, ST_FLOOR, ST_BNC_VY, ST_BNC_VX, ST_BNC_VZ, ST_BNC_WX,
        ST_BNC_WZ, ST_SPIN, ST_QT, ST_QH, ST_LSQ, ST_LEN, ST_LEN_W, ST_QN,
        ST_QN_W, ST_WB, ST_EMIT
    } t_bstate;

    // Quaternion product terms: component j, term t -> quaternion source, sign
    localparam logic [1:0] QT_QSEL [4][3] = '{
        '{2'd3, 2'd2, 2'd1},
        '{2'd2, 2'd3, 2'd0},
        '{2'd1, 2'd0, 2'd3},
        '{2'd0, 2'd1, 2'd2}
    };
    localparam logic QT_NEG [4][3] = '{
        '{1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b1}
    };

    function automatic t_val sat_add(t_val a, t_val b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) return s[32] ? VMIN : VMAX;
        return s[31:0];
    endfunction

    function automatic t_val sat_sub(t_val a, t_val b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31]) return s[32] ? VMIN : VMAX;
        return s[31:0];
    endfunction

    function automatic logic [31:0] mag(t_val a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    function automatic t_val sat_mag(logic neg, logic [47:0] m);
        if (m > 48'(VMAX)) return neg ? VMIN : VMAX;
        return neg ? t_val'(-m[31:0]) : t_val'(m[31:0]);
    endfunction

    // (a*b) >> 16 on magnitudes, saturated
    function automatic t_val mulq(t_val a, t_val b);
        logic [63:0] pr;
        pr = 64'(mag(a)) * 64'(mag(b));
        return sat_mag(a[31] ^ b[31], pr[63:16]);
    endfunction

endpackage

// File: src/frbs_if.sv
// ----------------------------------------------------------------------------
// frbs_if
// Valid/ready channels of the fragment step core.
// ----------------------------------------------------------------------------
interface frbs_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  fragment_index;
    logic [3:0]  field_select;
    logic signed [31:0] field_value;

    modport source (output valid, cmd, fragment_index, field_select, field_value,
                    input ready);
    modport sink   (input valid, cmd, fragment_index, field_select, field_value,
                    output ready);
endinterface

interface frbs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_rot_x;
    logic signed [31:0] out_rot_y;
    logic signed [31:0] out_rot_z;
    logic signed [31:0] out_rot_w;
    logic        out_active;

    modport source (output valid, out_index, out_pos_x, out_pos_y, out_pos_z,
                    out_rot_x, out_rot_y, out_rot_z, out_rot_w, out_active,
                    input ready);
    modport sink   (input valid, out_index, out_pos_x, out_pos_y, out_pos_z,
                    out_rot_x, out_rot_y, out_rot_z, out_rot_w, out_active,
                    output ready);
endinterface

interface frbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/frbs_ram.sv
// ----------------------------------------------------------------------------
// frbs_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module frbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/frbs_front.sv
// ----------------------------------------------------------------------------
// frbs_front
// Accepts items, classifies them and queues all but invalid writes for the back end.
// ----------------------------------------------------------------------------
module frbs_front
    import frbs_pkg::*;
#(
    parameter int FRAGMENT_COUNT = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frbs_in_if.sink    i_in,
    input  t_back_stat i_stat,
    output t_job       o_job,
    output logic       o_job_valid,
    input  logic       i_job_pop
);
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    t_job             r_q [QDEPTH];
    logic [QPW-1:0]   r_wp, r_rp;
    logic [QPW:0]     r_cnt;
    t_job             w_job;
    logic             w_in_range, w_push, w_acc;

    assign i_in.ready = (r_cnt != (QPW+1)'(QDEPTH)) && !i_stat.clearing;
    assign w_acc      = i_in.valid && i_in.ready;

    // classify
    always_comb begin
        w_in_range = 32'(i_in.fragment_index) < 32'(FRAGMENT_COUNT);
        w_job.idx  = i_in.fragment_index;
        w_job.sel  = i_in.field_select;
        w_job.val  = i_in.field_value;
        if (i_in.cmd == CMD_STEP) begin
            w_job.op = w_in_range ? OP_STEP : OP_STEP_NULL;
        end else if (w_in_range && i_in.field_select <= FS_LIVE) begin
            w_job.op = OP_WRITE;
        end else begin
            w_job.op = OP_NOP;
        end
    end

    assign w_push      = w_acc && (w_job.op != OP_NOP);
    assign o_job       = r_q[r_rp];
    assign o_job_valid = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + QPW'(1);
            if (i_job_pop) r_rp <= r_rp + QPW'(1);
            r_cnt <= r_cnt + (QPW+1)'(w_push) - (QPW+1)'(i_job_pop);
        end
    end
endmodule

// File: src/frbs_iter.sv
// ----------------------------------------------------------------------------
// frbs_iter
// Shared iterative unit: Q16.16 divide (one bit a cycle) or square root
// of s<<16 (one root bit a cycle).
// ----------------------------------------------------------------------------
module frbs_iter
    import frbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_iter_mode i_mode,
    input  t_val       i_a,
    input  t_val       i_b,
    output logic       o_done,
    output t_val       o_result
);
    logic        r_busy, r_done, r_neg, r_zero;
    t_iter_mode  r_mode;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [47:0] r_shift, r_quo;
    logic [31:0] r_div;

    logic [32:0] w_rem_sh, w_trial;
    logic        w_ge;

    always_comb begin
        if (r_mode == IT_DIV) begin
            w_rem_sh = {r_rem[31:0], r_shift[47]};
            w_trial  = {1'b0, r_div};
        end else begin
            w_rem_sh = {r_rem[30:0], r_shift[47:46]};
            w_trial  = {r_quo[30:0], 2'b01};
        end
        w_ge = w_rem_sh >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_rem  <= '0;
            r_quo  <= '0;
            r_neg  <= i_a[31] ^ i_b[31];
            r_div  <= mag(i_b);
            r_zero <= (i_mode == IT_DIV) && (i_b == '0);
            if (i_mode == IT_DIV) begin
                r_shift <= {mag(i_a), 16'd0};
                r_cnt   <= 6'd47;
            end else begin
                r_shift <= {i_a, 16'd0};
                r_cnt   <= 6'd23;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_quo <= {r_quo[46:0], w_ge};
            r_shift <= (r_mode == IT_DIV) ? {r_shift[46:0], 1'b0} : {r_shift[45:0], 2'b00};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_mode == IT_SQRT) ? t_val'(r_quo[31:0]) :
                      r_zero ? '0 : sat_mag(r_neg, r_quo);
endmodule

// File: src/frbs_back.sv
// ----------------------------------------------------------------------------
// frbs_back
// Executes queued items: field writes, and the rigid-body step sequencer
// around one shared multiplier and the shared divide/root unit.
// ----------------------------------------------------------------------------
module frbs_back
    import frbs_pkg::*;
#(
    parameter int FRAGMENT_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [30:0] i_time_step,
    input  logic [30:0] i_gravity,
    input  t_job        i_job,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    output t_back_stat  o_stat,
    frbs_out_if.source  o_out
);
    localparam int AW = $clog2(FRAGMENT_COUNT);

    t_bstate r_state, n_state;
    t_job    r_job, n_job;
    logic [AW-1:0] r_clr, n_clr;
    logic [1:0]    r_k, n_k, r_j, n_j;

    t_val r_p [3], n_p [3];
    t_val r_v [3], n_v [3];
    t_val r_w [3], n_w [3];
    t_val r_a [3], n_a [3];
    t_val r_q [4], n_q [4];
    t_val r_nq [4], n_nq [4];
    t_val r_m, n_m, r_area, n_area, r_acc, n_acc;
    t_val r_vmag, n_vmag, r_d, n_d, r_len, n_len;
    logic r_live, n_live;

    logic r_out_valid, n_out_valid;
    logic [7:0] r_o_idx, n_o_idx;
    t_val r_o_p [3], n_o_p [3];
    t_val r_o_q [4], n_o_q [4];
    logic r_o_act, n_o_act;

    t_val w_dt, w_g, w_mul_a, w_mul_b, w_mul;
    logic w_it_start, w_it_done;
    t_iter_mode w_it_mode;
    t_val w_it_a, w_it_b, w_it_res;

    logic w_wr_field, w_wb, w_live_we, w_live_wd, w_live_rd;
    logic [AW-1:0] w_live_waddr, w_raddr, w_waddr;
    t_val w_rd [N_FIELDS];
    t_val w_wbv [N_FIELDS];

    assign w_dt = t_val'({1'b0, i_time_step});
    assign w_g  = t_val'({1'b0, i_gravity});
    assign o_stat.clearing = (r_state == ST_CLEAR);

    // ---- entry store --------------------------------------------------
    assign w_wr_field = (r_state == ST_IDLE) && i_job_valid && (i_job.op == OP_WRITE);
    assign w_wb       = (r_state == ST_WB);
    assign w_raddr    = AW'(i_job.idx);
    assign w_waddr    = w_wr_field ? AW'(i_job.idx) : AW'(r_job.idx);

    for (genvar f = 0; f < N_FIELDS; f++) begin : g_field
        logic w_we;
        if (f < 3) begin : g_p
            assign w_wbv[f] = r_p[f];
        end else if (f < 6) begin : g_v
            assign w_wbv[f] = r_v[f-3];
        end else if (f < 9) begin : g_w
            assign w_wbv[f] = r_w[f-6];
        end else if (f < 13) begin : g_q
            assign w_wbv[f] = r_q[f-9];
        end else begin : g_m
            assign w_wbv[f] = r_m;
        end
        assign w_we = (w_wr_field && i_job.sel == 4'(f)) ||
                      (w_wb && 4'(f) != FS_MASS);
        frbs_ram #(.WIDTH(32), .DEPTH(FRAGMENT_COUNT)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wr_field ? i_job.val : w_wbv[f]),
            .i_raddr (w_raddr),
            .o_rdata (w_rd[f])
        );
    end

    assign w_live_we = (r_state == ST_CLEAR) || w_wb ||
                       (w_wr_field && i_job.sel == FS_LIVE);
    assign w_live_waddr = (r_state == ST_CLEAR) ? r_clr : w_waddr;
    assign w_live_wd = (r_state == ST_CLEAR) ? 1'b0 :
                       w_wr_field ? i_job.val[0] : r_live;

    frbs_ram #(.WIDTH(1), .DEPTH(FRAGMENT_COUNT)) u_live (
        .i_clk   (i_clk),
        .i_we    (w_live_we),
        .i_waddr (w_live_waddr),
        .i_wdata (w_live_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_live_rd)
    );

    frbs_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_it_start),
        .i_mode   (w_it_mode),
        .i_a      (w_it_a),
        .i_b      (w_it_b),
        .o_done   (w_it_done),
        .o_result (w_it_res)
    );

    // ---- shared multiplier operand select --------------------------------
    always_comb begin
        w_mul_a = r_acc;
        w_mul_b = w_dt;
        case (r_state)
            ST_AREA:   begin w_mul_a = r_m;       w_mul_b = C_AREA;     end
            ST_VSQ:    begin w_mul_a = r_v[r_k];  w_mul_b = r_v[r_k];   end
            ST_DRAG0:  begin w_mul_a = C_DRAG;    w_mul_b = r_area;     end
            ST_DRAG1:  begin w_mul_a = r_acc;     w_mul_b = r_vmag;     end
            ST_DV0:    begin w_mul_a = r_d;       w_mul_b = r_v[r_k];   end
            ST_DV1:    begin w_mul_a = r_acc;     w_mul_b = w_dt;       end
            ST_GRAV:   begin w_mul_a = w_g;       w_mul_b = w_dt;       end
            ST_POS:    begin w_mul_a = r_v[r_k];  w_mul_b = w_dt;       end
            ST_BNC_VY: begin w_mul_a = r_v[1];    w_mul_b = C_BOUNCE;   end
            ST_BNC_VX: begin w_mul_a = r_v[0];    w_mul_b = C_FRICTION; end
            ST_BNC_VZ: begin w_mul_a = r_v[2];    w_mul_b = C_FRICTION; end
            ST_BNC_WX: begin w_mul_a = r_w[0];    w_mul_b = C_HALF;     end
            ST_BNC_WZ: begin w_mul_a = r_w[2];    w_mul_b = C_HALF;     end
            ST_SPIN:   begin w_mul_a = r_w[r_k];  w_mul_b = w_dt;       end
            ST_QT:     begin w_mul_a = r_q[QT_QSEL[r_j][r_k]]; w_mul_b = r_a[r_k]; end
            ST_QH:     begin w_mul_a = r_acc;     w_mul_b = C_HALF;     end
            ST_LSQ:    begin w_mul_a = r_nq[r_k]; w_mul_b = r_nq[r_k];  end
            default:   begin w_mul_a = r_acc;     w_mul_b = w_dt;       end
        endcase
        w_mul = mulq(w_mul_a, w_mul_b);
    end

    // ---- next state ------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr == AW'(FRAGMENT_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.op)
                        OP_STEP:      n_state = ST_LOAD;
                        OP_STEP_NULL: n_state = ST_EMIT;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:   n_state = w_live_rd ? ST_AREA : ST_EMIT;
            ST_AREA:   n_state = ST_VSQ;
            ST_VSQ:    if (r_k == 2'd2) n_state = ST_VMAG;
            ST_VMAG:   n_state = (r_acc > 0) ? ST_VMAG_W : ST_DRAG0;
            ST_VMAG_W: if (w_it_done) n_state = ST_DRAG0;
            ST_DRAG0:  n_state = (r_vmag > C_SPEED_MIN && r_m > 0) ? ST_DRAG1 : ST_GRAV;
            ST_DRAG1:  n_state = ST_DDIV;
            ST_DDIV:   n_state = ST_DDIV_W;
            ST_DDIV_W: if (w_it_done) n_state = ST_DV0;
            ST_DV0:    n_state = ST_DV1;
            ST_DV1:    n_state = (r_k == 2'd2) ? ST_GRAV : ST_DV0;
            ST_GRAV:   n_state = ST_POS;
            ST_POS:    if (r_k == 2'd2) n_state = ST_FLOOR;
            ST_FLOOR:  n_state = (r_p[1] < C_FLOOR) ? ST_BNC_VY : ST_SPIN;
            ST_BNC_VY: n_state = ST_BNC_VX;
            ST_BNC_VX: n_state = ST_BNC_VZ;
            ST_BNC_VZ: n_state = ST_BNC_WX;
            ST_BNC_WX: n_state = ST_BNC_WZ;
            ST_BNC_WZ: n_state = ST_SPIN;
            ST_SPIN:   if (r_k == 2'd2) n_state = ST_QT;
            ST_QT:     if (r_k == 2'd2) n_state = ST_QH;
            ST_QH:     n_state = (r_j == 2'd3) ? ST_LSQ : ST_QT;
            ST_LSQ:    if (r_k == 2'd3) n_state = ST_LEN;
            ST_LEN:    n_state = (r_acc > 0) ? ST_LEN_W : ST_QN;
            ST_LEN_W:  if (w_it_done) n_state = ST_QN;
            ST_QN:     n_state = (r_len == '0) ? ST_WB : ST_QN_W;
            ST_QN_W:   if (w_it_done) n_state = (r_k == 2'd3) ? ST_WB : ST_QN;
            ST_WB:     n_state = ST_EMIT;
            ST_EMIT:   if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---- datapath and control --------------------------------------------
    always_comb begin
        n_job = r_job;   n_clr = r_clr;   n_k = r_k;   n_j = r_j;
        n_p = r_p;  n_v = r_v;  n_w = r_w;  n_a = r_a;  n_q = r_q;  n_nq = r_nq;
        n_m = r_m;  n_area = r_area;  n_acc = r_acc;  n_vmag = r_vmag;
        n_d = r_d;  n_len = r_len;  n_live = r_live;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_idx = r_o_idx;  n_o_p = r_o_p;  n_o_q = r_o_q;  n_o_act = r_o_act;
        o_job_pop  = 1'b0;
        w_it_start = 1'b0;
        w_it_mode  = IT_DIV;
        w_it_a     = r_acc;
        w_it_b     = r_m;
        case (r_state)
            ST_CLEAR: n_clr = r_clr + AW'(1);
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    if (i_job.op == OP_STEP_NULL) begin
                        n_p    = '{default: '0};
                        n_q    = '{default: '0};
                        n_live = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    n_p[i] = w_rd[i];
                    n_v[i] = w_rd[3+i];
                    n_w[i] = w_rd[6+i];
                end
                for (int i = 0; i < 4; i++) n_q[i] = w_rd[9+i];
                n_m    = w_rd[FS_MASS];
                n_live = w_live_rd;
            end
            ST_AREA: begin
                n_area = (w_mul < C_AREA_MIN) ? C_AREA_MIN : w_mul;
                n_acc  = '0;
                n_k    = '0;
            end
            ST_VSQ: begin
                n_acc = sat_add(r_acc, w_mul);
                n_k   = r_k + 2'd1;
            end
            ST_VMAG: begin
                if (r_acc > 0) begin
                    w_it_start = 1'b1;
                    w_it_mode  = IT_SQRT;
                end else begin
                    n_vmag = '0;
                end
            end
            ST_VMAG_W: if (w_it_done) n_vmag = w_it_res;
            ST_DRAG0:  n_acc = w_mul;
            ST_DRAG1:  n_acc = w_mul;
            ST_DDIV:   w_it_start = 1'b1;
            ST_DDIV_W: begin
                if (w_it_done) n_d = w_it_res;
                n_k = '0;
            end
            ST_DV0: n_acc = w_mul;
            ST_DV1: begin
                n_v[r_k] = sat_sub(r_v[r_k], w_mul);
                n_k      = r_k + 2'd1;
            end
            ST_GRAV: begin
                n_v[1] = sat_sub(r_v[1], w_mul);
                n_k    = '0;
            end
            ST_POS: begin
                n_p[r_k] = sat_add(r_p[r_k], w_mul);
                n_k      = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            ST_FLOOR: if (r_p[1] < C_FLOOR) n_p[1] = C_FLOOR;
            ST_BNC_VY: begin
                n_v[1] = w_mul;
                if (w_mul < C_REST && w_mul > -C_REST) n_live = 1'b0;
            end
            ST_BNC_VX: n_v[0] = w_mul;
            ST_BNC_VZ: n_v[2] = w_mul;
            ST_BNC_WX: n_w[0] = w_mul;
            ST_BNC_WZ: n_w[2] = w_mul;
            ST_SPIN: begin
                n_a[r_k] = w_mul;
                n_k      = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                n_j      = '0;
                n_acc    = '0;
            end
            ST_QT: begin
                n_acc = QT_NEG[r_j][r_k] ? sat_sub(r_acc, w_mul) : sat_add(r_acc, w_mul);
                n_k   = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            ST_QH: begin
                n_nq[r_j] = sat_add(r_q[r_j], w_mul);
                n_acc     = '0;
                n_j       = r_j + 2'd1;
                n_k       = '0;
            end
            ST_LSQ: begin
                n_acc = sat_add(r_acc, w_mul);
                n_k   = r_k + 2'd1;
            end
            ST_LEN: begin
                if (r_acc > 0) begin
                    w_it_start = 1'b1;
                    w_it_mode  = IT_SQRT;
                end else begin
                    n_len = '0;
                end
                n_k = '0;
            end
            ST_LEN_W: if (w_it_done) n_len = w_it_res;
            ST_QN: begin
                if (r_len == '0) begin
                    n_q = r_nq;
                end else begin
                    w_it_start = 1'b1;
                    w_it_a     = r_nq[r_k];
                    w_it_b     = r_len;
                end
            end
            ST_QN_W: begin
                if (w_it_done) begin
                    n_q[r_k] = w_it_res;
                    n_k      = r_k + 2'd1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_idx     = r_job.idx;
                    n_o_p       = r_p;
                    n_o_q       = r_q;
                    n_o_act     = r_live;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;   r_k <= n_k;   r_j <= n_j;
        r_p    <= n_p;     r_v <= n_v;   r_w <= n_w;   r_a <= n_a;
        r_q    <= n_q;     r_nq <= n_nq;
        r_m    <= n_m;     r_area <= n_area;   r_acc <= n_acc;
        r_vmag <= n_vmag;  r_d <= n_d;   r_len <= n_len;   r_live <= n_live;
        r_o_idx <= n_o_idx;  r_o_p <= n_o_p;  r_o_q <= n_o_q;  r_o_act <= n_o_act;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_index  = r_o_idx;
    assign o_out.out_pos_x  = r_o_p[0];
    assign o_out.out_pos_y  = r_o_p[1];
    assign o_out.out_pos_z  = r_o_p[2];
    assign o_out.out_rot_x  = r_o_q[0];
    assign o_out.out_rot_y  = r_o_q[1];
    assign o_out.out_rot_z  = r_o_q[2];
    assign o_out.out_rot_w  = r_o_q[3];
    assign o_out.out_active = r_o_act;
endmodule

// File: src/fragment_rigid_body_step_core.sv
// ----------------------------------------------------------------------------
// fragment_rigid_body_step_core
// Table of rigid fragments stepped one at a time by semi-implicit Euler with
// quadratic drag, gravity, floor bounce and quaternion integration (Q16.16).
// ----------------------------------------------------------------------------
// Items enter through a four-deep queue, so the input keeps taking items while
// a step is in progress until the queue is full. A field write is done by the
// back end once it reaches the head of the queue. A step of a live entry runs
// an arithmetic sequence on one shared 32x32 multiplier, plus the shared
// divide/square-root unit, which gives one bit a cycle (two roots, the drag
// divide and up to four quaternion divides, each begun from a start state).
// Steps without drag, bounce or a non-zero quaternion are shorter. A step of
// an inactive entry passes only the load and emit states, one of an
// out-of-table entry goes straight to emit. The result register lets the next
// item start while the previous result waits. After reset the active flags
// are cleared by a pass over all entries, during which no item is taken;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module fragment_rigid_body_step_core
    import frbs_pkg::*;
#(
    parameter int FRAGMENT_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frbs_in_if.sink     i_in,
    frbs_out_if.source  o_out,
    frbs_cfg_if.sink    i_cfg
);
    // Configuration registers
    logic [30:0] r_time_step, r_gravity;

    t_job       w_job;
    logic       w_job_valid, w_job_pop;
    t_back_stat w_stat;

    // Config port never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= 31'd3277;
            r_gravity   <= 31'd642689;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TIME_STEP: r_time_step <= i_cfg.data[30:0];
                CFG_GRAVITY:   r_gravity   <= i_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // Front: accept, classify, queue
    frbs_front #(.FRAGMENT_COUNT(FRAGMENT_COUNT)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_stat      (w_stat),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop)
    );

    // Back: entry store, step sequencer, result register
    frbs_back #(.FRAGMENT_COUNT(FRAGMENT_COUNT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_time_step (r_time_step),
        .i_gravity   (r_gravity),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .o_stat      (w_stat),
        .o_out       (o_out)
    );
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fragment step core: field writes and step
// items go in through a randomly idling driver, each step is predicted in
// fixed point at acceptance and its result is checked in order by a randomly
// stalling monitor, across several time step and gravity settings.
// ----------------------------------------------------------------------------
module tb_top;
    import frbs_pkg::*;

    localparam int           N_FRAG       = 256;
    localparam int           WATCH_LIMIT  = 30000;   // idle cycles before giving up
    localparam int           LONG_HOLD    = 3000;    // receiver hold-off, cycles
    localparam int           SETTLE       = 40;      // covers queued writes
    localparam int           RANDOM_ITEMS = 1150;
    localparam logic [3:0]   FS_POS_X     = 4'd0;
    localparam logic [3:0]   FS_VEL_X     = 4'd3;
    localparam logic [3:0]   FS_SPIN_X    = 4'd6;
    localparam logic [3:0]   FS_QUAT_X    = 4'd9;
    localparam logic [3:0]   FS_UNUSED    = 4'd15;
    localparam longint       VMAX_L       = 64'sd2147483647;
    localparam longint       VMIN_L       = -64'sd2147483648;

    typedef struct {
        logic        cmd;
        logic [7:0]  idx;
        logic [3:0]  sel;
        t_val        val;
    } t_frag_item;

    typedef struct {
        logic [7:0]  idx;
        t_val        pos [3];
        t_val        rot [4];
        logic        active;
    } t_frag_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    frbs_in_if  in_ch ();
    frbs_out_if out_ch ();
    frbs_cfg_if cfg_ch ();

    fragment_rigid_body_step_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    // ---- bench state ----
    t_frag_item  pending_items [$];
    t_frag_state expected_steps [$];
    int          fail_count = 0;
    bit          long_hold_req = 1'b0;
    logic [13:0] loaded_fields [N_FRAG];   // fields written so far, per entry

    // Predictor copy of the table and the registers
    longint frag_pos  [N_FRAG][3];
    longint frag_vel  [N_FRAG][3];
    longint frag_spin [N_FRAG][3];
    longint frag_quat [N_FRAG][4];
    longint frag_mass [N_FRAG];
    bit     frag_live [N_FRAG];
    longint cur_dt   = 3277;
    longint cur_grav = 642689;

    // ---- fixed-point arithmetic, 32-bit Q16.16 with saturation ----
    function automatic longint clamp32(longint v);
        if (v > VMAX_L) return VMAX_L;
        if (v < VMIN_L) return VMIN_L;
        return v;
    endfunction

    function automatic longint add_q(longint a, longint b);
        return clamp32(clamp32(a) + clamp32(b));
    endfunction

    function automatic longint sub_q(longint a, longint b);
        return clamp32(clamp32(a) - clamp32(b));
    endfunction

    function automatic longint mul_q(longint a, longint b);
        longint unsigned ua, ub, m;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        m   = (ua * ub) >> 16;
        if (neg) return (m > 64'd2147483648) ? VMIN_L : -longint'(m);
        return (m > 64'd2147483647) ? VMAX_L : longint'(m);
    endfunction

    function automatic longint div_q(longint a, longint b);
        longint unsigned ua, ub, m;
        bit neg;
        neg = (a < 0) != (b < 0);
        a   = clamp32(a);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        if (ub == 0) return 0;
        m = (ua << 16) / ub;
        if (neg) return (m > 64'd2147483648) ? VMIN_L : -longint'(m);
        return (m > 64'd2147483647) ? VMAX_L : longint'(m);
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // length of a 3- or 4-vector: root of the saturated sum of squares
    function automatic longint vec_len(longint v [4], int n);
        longint s;
        s = 0;
        for (int k = 0; k < n; k++) s = add_q(s, mul_q(v[k], v[k]));
        if (s <= 0) return 0;
        return clamp32(root_floor(longint'(s) << 16));
    endfunction

    // ---- predictor: apply one accepted item to the table ----
    task automatic apply_item(t_frag_item it);
        t_frag_state r;
        longint v [4], nq [4], a [3], old [3];
        longint m, area, vmag, d, len, dt;
        int     i;
        bit     live;
        i  = it.idx;
        dt = cur_dt;
        if (it.cmd == CMD_WRITE) begin
            if (it.sel < 3)               frag_pos[i][it.sel]       = it.val;
            else if (it.sel < 6)          frag_vel[i][it.sel - 3]   = it.val;
            else if (it.sel < 9)          frag_spin[i][it.sel - 6]  = it.val;
            else if (it.sel < 13)         frag_quat[i][it.sel - 9]  = it.val;
            else if (it.sel == FS_MASS)   frag_mass[i]              = it.val;
            else if (it.sel == FS_LIVE)   frag_live[i]              = it.val[0];
            return;
        end
        live = frag_live[i];
        if (live) begin
            m    = frag_mass[i];
            area = mul_q(m, C_AREA);
            if (area < C_AREA_MIN) area = C_AREA_MIN;
            v = '{frag_vel[i][0], frag_vel[i][1], frag_vel[i][2], 0};
            vmag = vec_len(v, 3);
            // quadratic drag, all components from the pre-drag velocity
            if (vmag > C_SPEED_MIN && m > 0) begin
                d = div_q(mul_q(mul_q(C_DRAG, area), vmag), m);
                for (int k = 0; k < 3; k++) old[k] = frag_vel[i][k];
                for (int k = 0; k < 3; k++)
                    frag_vel[i][k] = sub_q(frag_vel[i][k], mul_q(mul_q(d, old[k]), dt));
            end
            frag_vel[i][1] = sub_q(frag_vel[i][1], mul_q(cur_grav, dt));
            for (int k = 0; k < 3; k++)
                frag_pos[i][k] = add_q(frag_pos[i][k], mul_q(frag_vel[i][k], dt));
            // floor: clamp, bounce, friction, spin damping, rest test
            if (frag_pos[i][1] < C_FLOOR) begin
                frag_pos[i][1]  = C_FLOOR;
                frag_vel[i][1]  = mul_q(frag_vel[i][1], C_BOUNCE);
                frag_vel[i][0]  = mul_q(frag_vel[i][0], C_FRICTION);
                frag_vel[i][2]  = mul_q(frag_vel[i][2], C_FRICTION);
                frag_spin[i][0] = mul_q(frag_spin[i][0], C_HALF);
                frag_spin[i][2] = mul_q(frag_spin[i][2], C_HALF);
                if (frag_vel[i][1] < C_REST && frag_vel[i][1] > -C_REST) live = 1'b0;
            end
            for (int k = 0; k < 3; k++) a[k] = mul_q(frag_spin[i][k], dt);
            v = frag_quat[i];
            nq[0] = add_q(v[0], mul_q(add_q(sub_q(mul_q(v[3], a[0]), mul_q(v[2], a[1])),
                                            mul_q(v[1], a[2])), C_HALF));
            nq[1] = add_q(v[1], mul_q(sub_q(add_q(mul_q(v[2], a[0]), mul_q(v[3], a[1])),
                                            mul_q(v[0], a[2])), C_HALF));
            // plain negation first: a negated minimum saturates inside the add
            nq[2] = add_q(v[2], mul_q(add_q(add_q(-mul_q(v[1], a[0]), mul_q(v[0], a[1])),
                                            mul_q(v[3], a[2])), C_HALF));
            nq[3] = add_q(v[3], mul_q(sub_q(sub_q(-mul_q(v[0], a[0]), mul_q(v[1], a[1])),
                                            mul_q(v[2], a[2])), C_HALF));
            len = vec_len(nq, 4);
            for (int k = 0; k < 4; k++) frag_quat[i][k] = (len > 0) ? div_q(nq[k], len) : nq[k];
            frag_live[i] = live;
        end
        r.idx = it.idx;
        for (int k = 0; k < 3; k++) r.pos[k] = t_val'(frag_pos[i][k]);
        for (int k = 0; k < 4; k++) r.rot[k] = t_val'(frag_quat[i][k]);
        r.active = live;
        expected_steps = {expected_steps, r};
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    // ---- driver ----
    int  send_gap = 0;
    bit  send_eager = 1'b0;    // stretches with no idling
    always @(posedge i_clk) begin
        bit taken;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            taken = in_ch.valid && in_ch.ready;
            if (taken) begin
                apply_item(pending_items.pop_front());
                if ($urandom_range(0, 99) == 0) send_eager = ~send_eager;
                send_gap = send_eager ? 0 : $urandom_range(0, 18);
            end
            if (!in_ch.valid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_ch.valid          <= 1'b1;
                    in_ch.cmd            <= pending_items[0].cmd;
                    in_ch.fragment_index <= pending_items[0].idx;
                    in_ch.field_select   <= pending_items[0].sel;
                    in_ch.field_value    <= pending_items[0].val;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---- monitor and checker ----
    int  recv_wait = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  recv_eager = 1'b0;
    always @(posedge i_clk) begin
        t_frag_state w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_steps.size() == 0) begin
                    $display("unexpected result for entry %0d", out_ch.out_index);
                    fail_count++;
                end else begin
                    w = expected_steps.pop_front();
                    if (out_ch.out_index !== w.idx)    report("index", out_ch.out_index, w.idx);
                    if (out_ch.out_pos_x !== w.pos[0]) report("pos_x", out_ch.out_pos_x, w.pos[0]);
                    if (out_ch.out_pos_y !== w.pos[1]) report("pos_y", out_ch.out_pos_y, w.pos[1]);
                    if (out_ch.out_pos_z !== w.pos[2]) report("pos_z", out_ch.out_pos_z, w.pos[2]);
                    if (out_ch.out_rot_x !== w.rot[0]) report("rot_x", out_ch.out_rot_x, w.rot[0]);
                    if (out_ch.out_rot_y !== w.rot[1]) report("rot_y", out_ch.out_rot_y, w.rot[1]);
                    if (out_ch.out_rot_z !== w.rot[2]) report("rot_z", out_ch.out_rot_z, w.rot[2]);
                    if (out_ch.out_rot_w !== w.rot[3]) report("rot_w", out_ch.out_rot_w, w.rot[3]);
                    if (out_ch.out_active !== w.active)
                        report("active", out_ch.out_active, w.active);
                end
                if ($urandom_range(0, 29) == 0) recv_eager = ~recv_eager;
                recv_wait = recv_eager ? 0 : $urandom_range(0, 18);
            end
            // one long hold-off, so the input queue fills behind it
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---- watchdog: cycles with no item moving on any channel ----
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("fragment_rigid_body_step_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---- stimulus helpers ----
    function automatic bit is_loaded(int i);
        return &loaded_fields[i];
    endfunction

    task automatic push_item(logic cmd, int idx, logic [3:0] sel, t_val val);
        t_frag_item it;
        it = '{cmd: cmd, idx: 8'(idx), sel: sel, val: val};
        if (cmd == CMD_WRITE && sel < FS_LIVE) loaded_fields[idx][sel] = 1'b1;
        pending_items = {pending_items, it};
    endtask

    function automatic t_val span(int lo, int hi);
        return t_val'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Full load of one entry, then its live flag
    task automatic load_entry(int idx, t_val f [14]);
        for (int k = 0; k < 14; k++) push_item(CMD_WRITE, idx, 4'(k), f[k]);
        push_item(CMD_WRITE, idx, FS_LIVE, {$urandom()} | 32'd1);
    endtask

    task automatic well_formed_run(output int n);
        t_val f [14];
        int   idx, kind, steps;
        idx  = $urandom_range(0, N_FRAG - 1);
        kind = $urandom_range(0, 5);
        for (int k = 0; k < 3; k++) begin
            f[FS_POS_X + k]  = span(-327680, 327680);
            f[FS_VEL_X + k]  = span(-1310720, 1310720);
            f[FS_SPIN_X + k] = span(-655360, 655360);
        end
        for (int k = 0; k < 4; k++) f[FS_QUAT_X + k] = span(-65536, 65536);
        f[FS_MASS] = span(6554, 655360);
        case (kind)
            1: begin    // resting on the floor: slow bounce, entry may go to rest
                f[FS_POS_X + 1] = span(-32768, -32668);
                f[FS_VEL_X + 1] = span(-19660, -3000);
            end
            2: begin    // hitting the floor fast: bounces and stays live
                f[FS_POS_X + 1] = span(-32768, -20000);
                f[FS_VEL_X + 1] = span(-1310720, -655360);
            end
            3: f[FS_MASS] = ($urandom_range(0, 1) != 0) ? t_val'(0) : span(-655360, -1);
            4: begin    // degenerate orientation, no spin
                for (int k = 0; k < 4; k++) f[FS_QUAT_X + k] = '0;
                for (int k = 0; k < 3; k++) f[FS_SPIN_X + k] = '0;
            end
            5: for (int k = 0; k < 14; k++) f[k] = $urandom();
            default: ;
        endcase
        load_entry(idx, f);
        steps = $urandom_range(1, 5);
        for (int s = 0; s < steps; s++) push_item(CMD_STEP, idx, 4'($urandom()), $urandom());
        n = 15 + steps;
    endtask

    task automatic noise_item();
        int   idx, tries;
        t_val v;
        idx = $urandom_range(0, N_FRAG - 1);
        v   = $urandom();
        case ($urandom_range(0, 3))
            0: push_item(CMD_WRITE, idx, 4'($urandom_range(0, 13)), v);
            // a live flag only goes up on a fully loaded entry
            1: push_item(CMD_WRITE, idx, FS_LIVE, is_loaded(idx) ? v : (v & ~32'd1));
            2: push_item(CMD_WRITE, idx, FS_UNUSED, v);
            default: begin
                tries = 0;
                while (!is_loaded(idx) && tries < 30) begin
                    idx = $urandom_range(0, N_FRAG - 1);
                    tries++;
                end
                if (is_loaded(idx)) push_item(CMD_STEP, idx, 4'($urandom()), v);
                else push_item(CMD_WRITE, idx, FS_UNUSED, v);
            end
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_steps.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        // writes still in the block's queue
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] index, logic [30:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= {$urandom_range(0, 1) != 0, value};   // top bit is ignored
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (index == CFG_TIME_STEP) cur_dt = value;
        else cur_grav = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // ---- sequence ----
    initial begin
        t_val   ext [14];
        int     sent, n;
        logic [30:0] dt_set [5], grav_set [5];
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_WRITE;
        in_ch.fragment_index = '0;
        in_ch.field_select = '0;
        in_ch.field_value = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        for (int i = 0; i < N_FRAG; i++) begin
            loaded_fields[i] = '0;
            frag_live[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: an entry at the top of the table with extreme fields
        ext = '{VMAX, VMIN, '0, VMIN, VMAX, -32'sd1, VMAX, VMIN, 32'sd1,
                VMAX, VMIN, '0, VMAX, VMAX};
        load_entry(N_FRAG - 1, ext);
        push_item(CMD_STEP, N_FRAG - 1, '0, '0);
        push_item(CMD_STEP, N_FRAG - 1, 4'hf, VMIN);
        push_item(CMD_WRITE, N_FRAG - 1, FS_UNUSED, VMAX);
        push_item(CMD_WRITE, N_FRAG - 1, FS_LIVE, 32'hfffffffe);
        push_item(CMD_STEP, N_FRAG - 1, '0, '0);     // not live: passed through
        push_item(CMD_WRITE, 0, FS_LIVE, '0);
        wait_drained();

        // Register settings, extremes included; reset values first
        dt_set   = '{31'd3277, 31'd0, 31'h7fffffff, 31'd65536, 31'($urandom_range(1, 20000))};
        grav_set = '{31'd642689, 31'd0, 31'h7fffffff, 31'd0, 31'($urandom())};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_TIME_STEP, dt_set[ph]);
            write_reg(CFG_GRAVITY, grav_set[ph]);
            sent = 0;
            while (sent < RANDOM_ITEMS / 5) begin
                if ($urandom_range(0, 3) != 0) begin
                    well_formed_run(n);
                    sent += n;
                end else begin
                    noise_item();
                    sent++;
                end
                if (ph == 0 && sent >= 40 && !long_hold_req) long_hold_req = 1'b1;
                // sender pauses mid-phase until everything has come back
                if (ph == 2 && sent >= 100 && sent < 120) begin
                    wait_drained();
                    sent = 120;
                end
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("fragment_rigid_body_step_core test passed");
        end else begin
            $display("fragment_rigid_body_step_core test failed");
        end
        $finish;
    end

endmodule
